// ===== design/brc_pkg.sv =====
package brc_pkg;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_RUN  = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_TEMP_TRIM    = 2'd0;
   localparam logic [1:0] CSR_PRESS_TRIM_A = 2'd1;
   localparam logic [1:0] CSR_PRESS_TRIM_B = 2'd2;
   localparam logic [1:0] CSR_PRESS_TRIM_C = 2'd3;

   // Microprogram step addresses
   localparam logic [4:0] PC_TEMP_START  = 5'd0;
   localparam logic [4:0] PC_T_V1        = 5'd1;
   localparam logic [4:0] PC_T_V2A       = 5'd2;
   localparam logic [4:0] PC_T_FINE      = 5'd3;
   localparam logic [4:0] PC_T_OUT       = 5'd4;
   localparam logic [4:0] PC_PRESS_START = 5'd16;
   localparam logic [4:0] PC_P_SQ        = 5'd17;
   localparam logic [4:0] PC_P_V2A       = 5'd18;
   localparam logic [4:0] PC_P_V2B       = 5'd19;
   localparam logic [4:0] PC_P_V1A       = 5'd20;
   localparam logic [4:0] PC_P_V1B       = 5'd21;
   localparam logic [4:0] PC_P_V1C       = 5'd22;
   localparam logic [4:0] PC_P_CHK       = 5'd23;
   localparam logic [4:0] PC_P_NUM       = 5'd24;
   localparam logic [4:0] PC_P_DIV       = 5'd25;
   localparam logic [4:0] PC_P_QUO       = 5'd26;
   localparam logic [4:0] PC_P_H2        = 5'd27;
   localparam logic [4:0] PC_P_V1D       = 5'd28;
   localparam logic [4:0] PC_P_SUM       = 5'd29;
   localparam logic [4:0] PC_P_OUT       = 5'd30;

   localparam logic [63:0] FINE_OFFSET  = 64'd128000;
   localparam logic [63:0] ADC_FULL     = 64'd1048576;
   localparam logic [63:0] PRESS_SCALE  = 64'd3125;
   localparam logic [63:0] V1_BIAS      = 64'd1 << 47;
   localparam logic [31:0] TEMP_SCALE   = 32'd5;
   localparam logic [31:0] TEMP_ROUND   = 32'd128;

endpackage

// ===== design/barometer_reading_compensation.sv =====
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  tdata: msb, lsb, xlsb bytes; tuser: type
// rsp_      out  rsp_tvalid/rsp_tready  tdata: temp, pressure; tuser: is_press, div0
// csr_      in   csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// Item timing is set by the shared 32x32 multiplier, which builds each 64-bit
// product from its low and cross partial products, and by the radix-2 divider
// that pressure items use. req_tready is high only while the sequencer idles.
// A finished result waits in the output register; a new item is taken meanwhile.
// Reset clears the trim registers, the stored fine temperature and all control.
module barometer_reading_compensation import brc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // msb_byte, lsb_byte, xlsb_byte
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // temperature_centi, pressure_q24_8
   output logic [1:0]  rsp_tuser,   // result_is_pressure, divide_by_zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   state_type   state_ff, state_in;
   logic [4:0]  pc_ff, pc_in;
   logic [19:0] adc_ff, adc_in;
   logic        kind_ff, kind_in;
   logic [63:0] x_ff, x_in, y_ff, y_in, p_ff, p_in, h_ff, h_in;
   logic [63:0] prod_ff, prod_in, ma_ff, ma_in, mb_ff, mb_in;
   logic [1:0]  mcnt_ff, mcnt_in;
   logic [63:0] rem_ff, rem_in, quo_ff, quo_in, dm_ff, dm_in;
   logic        qneg_ff, qneg_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic [31:0] fine_ff, fine_in;
   logic [31:0] rtemp_ff, rtemp_in, rpress_ff, rpress_in;
   logic        rdz_ff, rdz_in;
   logic [47:0] ttrim_ff;
   logic [63:0] ptrim_a_ff, ptrim_b_ff;
   logic [15:0] ptrim_c_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;

   logic [31:0] mul_x, mul_y;
   logic [63:0] mul_p;
   logic [64:0] rem_sh;
   logic        div_ge;

   logic [31:0] t1, t2, t3;
   logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

   assign t1 = {16'd0, ttrim_ff[15:0]};
   assign t2 = {{16{ttrim_ff[31]}}, ttrim_ff[31:16]};
   assign t3 = {{16{ttrim_ff[47]}}, ttrim_ff[47:32]};
   assign p1 = {48'd0, ptrim_a_ff[15:0]};
   assign p2 = {{48{ptrim_a_ff[31]}}, ptrim_a_ff[31:16]};
   assign p3 = {{48{ptrim_a_ff[47]}}, ptrim_a_ff[47:32]};
   assign p4 = {{48{ptrim_a_ff[63]}}, ptrim_a_ff[63:48]};
   assign p5 = {{48{ptrim_b_ff[15]}}, ptrim_b_ff[15:0]};
   assign p6 = {{48{ptrim_b_ff[31]}}, ptrim_b_ff[31:16]};
   assign p7 = {{48{ptrim_b_ff[47]}}, ptrim_b_ff[47:32]};
   assign p8 = {{48{ptrim_b_ff[63]}}, ptrim_b_ff[63:48]};
   assign p9 = {{48{ptrim_c_ff[15]}}, ptrim_c_ff};

   // Shared multiplier: one 32x32 partial product per cycle
   always_comb begin
      unique case (mcnt_ff)
         2'd0: begin
            mul_x = ma_ff[31:0];
            mul_y = mb_ff[31:0];
         end
         2'd1: begin
            mul_x = ma_ff[31:0];
            mul_y = mb_ff[63:32];
         end
         default: begin
            mul_x = ma_ff[63:32];
            mul_y = mb_ff[31:0];
         end
      endcase
   end
   assign mul_p = mul_x * mul_y;

   // Restoring divider step on magnitudes
   assign rem_sh = {rem_ff, quo_ff[63]};
   assign div_ge = rem_sh >= {1'b0, dm_ff};

   always_comb begin
      logic [31:0] a32, d32, tf;
      logic [63:0] v, q;
      state_in  = state_ff;
      pc_in     = pc_ff;
      adc_in    = adc_ff;
      kind_in   = kind_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      p_in      = p_ff;
      h_in      = h_ff;
      prod_in   = prod_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      mcnt_in   = mcnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dm_in     = dm_ff;
      qneg_in   = qneg_ff;
      dcnt_in   = dcnt_ff;
      fine_in   = fine_ff;
      rtemp_in  = rtemp_ff;
      rpress_in = rpress_ff;
      rdz_in    = rdz_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      a32 = '0;
      d32 = '0;
      tf  = '0;
      v   = '0;
      q   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               adc_in    = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:20]};
               kind_in   = req_tuser;
               pc_in     = req_tuser ? PC_PRESS_START : PC_TEMP_START;
               rtemp_in  = '0;
               rpress_in = '0;
               rdz_in    = 1'b0;
               state_in  = ST_RUN;
            end
         end
         ST_MUL: begin
            // Accumulate the low and the two cross partial products
            if (mcnt_ff == 2'd0) begin
               prod_in = mul_p;
            end else begin
               prod_in = prod_ff + {mul_p[31:0], 32'd0};
            end
            mcnt_in = mcnt_ff + 2'd1;
            if (mcnt_ff == 2'd2) begin
               state_in = ST_RUN;
            end
         end
         ST_DIV: begin
            rem_in  = div_ge ? rem_sh[63:0] - dm_ff : rem_sh[63:0];
            quo_in  = {quo_ff[62:0], div_ge};
            dcnt_in = dcnt_ff + 6'd1;
            if (dcnt_ff == 6'd63) begin
               state_in = ST_RUN;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {rpress_ff, rtemp_ff};
               rsp_user_in  = {rdz_ff, kind_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            // ST_RUN: execute one microprogram step
            pc_in   = pc_ff + 5'd1;
            mcnt_in = 2'd0;
            unique case (pc_ff)
               PC_TEMP_START: begin
                  a32 = {15'd0, adc_ff[19:3]} - {t1[30:0], 1'b0};
                  ma_in = {32'd0, a32};
                  mb_in = {32'd0, t2};
                  state_in = ST_MUL;
               end
               PC_T_V1: begin
                  x_in  = {32'd0, 32'($signed(prod_ff[31:0]) >>> 11)};
                  d32   = {16'd0, adc_ff[19:4]} - t1;
                  ma_in = {32'd0, d32};
                  mb_in = {32'd0, d32};
                  state_in = ST_MUL;
               end
               PC_T_V2A: begin
                  ma_in = {32'd0, 32'($signed(prod_ff[31:0]) >>> 12)};
                  mb_in = {32'd0, t3};
                  state_in = ST_MUL;
               end
               PC_T_FINE: begin
                  tf = x_ff[31:0] + 32'($signed(prod_ff[31:0]) >>> 14);
                  fine_in = tf;
                  ma_in = {32'd0, tf};
                  mb_in = {32'd0, TEMP_SCALE};
                  state_in = ST_MUL;
               end
               PC_T_OUT: begin
                  rtemp_in = 32'($signed(prod_ff[31:0] + TEMP_ROUND) >>> 8);
                  state_in = ST_DONE;
               end
               PC_PRESS_START: begin
                  v = {{32{fine_ff[31]}}, fine_ff} - FINE_OFFSET;
                  x_in  = v;
                  ma_in = v;
                  mb_in = v;
                  state_in = ST_MUL;
               end
               PC_P_SQ: begin
                  h_in  = prod_ff;
                  ma_in = prod_ff;
                  mb_in = p6;
                  state_in = ST_MUL;
               end
               PC_P_V2A: begin
                  y_in  = prod_ff;
                  ma_in = x_ff;
                  mb_in = p5;
                  state_in = ST_MUL;
               end
               PC_P_V2B: begin
                  y_in  = y_ff + (prod_ff << 17) + (p4 << 35);
                  ma_in = h_ff;
                  mb_in = p3;
                  state_in = ST_MUL;
               end
               PC_P_V1A: begin
                  p_in  = 64'($signed(prod_ff) >>> 8);
                  ma_in = x_ff;
                  mb_in = p2;
                  state_in = ST_MUL;
               end
               PC_P_V1B: begin
                  x_in = p_ff + (prod_ff << 12) + V1_BIAS;
               end
               PC_P_V1C: begin
                  ma_in = x_ff;
                  mb_in = p1;
                  state_in = ST_MUL;
               end
               PC_P_CHK: begin
                  v = 64'($signed(prod_ff) >>> 33);
                  x_in = v;
                  p_in = ADC_FULL - {44'd0, adc_ff};
                  if (v == 64'd0) begin
                     // Zero divisor: force the pressure to zero and flag it
                     rdz_in   = 1'b1;
                     state_in = ST_DONE;
                  end
               end
               PC_P_NUM: begin
                  ma_in = (p_ff << 31) - y_ff;
                  mb_in = PRESS_SCALE;
                  state_in = ST_MUL;
               end
               PC_P_DIV: begin
                  quo_in  = prod_ff[63] ? 64'd0 - prod_ff : prod_ff;
                  dm_in   = x_ff[63] ? 64'd0 - x_ff : x_ff;
                  qneg_in = prod_ff[63] ^ x_ff[63];
                  rem_in  = '0;
                  dcnt_in = '0;
                  state_in = ST_DIV;
               end
               PC_P_QUO: begin
                  q = qneg_ff ? 64'd0 - quo_ff : quo_ff;
                  v = 64'($signed(q) >>> 13);
                  p_in  = q;
                  h_in  = v;
                  ma_in = p9;
                  mb_in = v;
                  state_in = ST_MUL;
               end
               PC_P_H2: begin
                  ma_in = prod_ff;
                  mb_in = h_ff;
                  state_in = ST_MUL;
               end
               PC_P_V1D: begin
                  x_in  = 64'($signed(prod_ff) >>> 25);
                  ma_in = p8;
                  mb_in = p_ff;
                  state_in = ST_MUL;
               end
               PC_P_SUM: begin
                  p_in = p_ff + x_ff + 64'($signed(prod_ff) >>> 19);
               end
               PC_P_OUT: begin
                  v = 64'($signed(p_ff) >>> 8) + (p7 << 4);
                  rpress_in = v[31:0];
                  state_in  = ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
      endcase
   end

   // Control and configuration state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fine_ff      <= '0;
         ttrim_ff     <= '0;
         ptrim_a_ff   <= '0;
         ptrim_b_ff   <= '0;
         ptrim_c_ff   <= '0;
         pc_ff        <= '0;
         mcnt_ff      <= '0;
         dcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fine_ff      <= fine_in;
         pc_ff        <= pc_in;
         mcnt_ff      <= mcnt_in;
         dcnt_ff      <= dcnt_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_TEMP_TRIM:    ttrim_ff   <= csr_data[47:0];
               CSR_PRESS_TRIM_A: ptrim_a_ff <= csr_data;
               CSR_PRESS_TRIM_B: ptrim_b_ff <= csr_data;
               CSR_PRESS_TRIM_C: ptrim_c_ff <= csr_data[15:0];
               default:          ptrim_c_ff <= ptrim_c_ff;
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      adc_ff      <= adc_in;
      kind_ff     <= kind_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      p_ff        <= p_in;
      h_ff        <= h_in;
      prod_ff     <= prod_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dm_ff       <= dm_in;
      qneg_ff     <= qneg_in;
      rtemp_ff    <= rtemp_in;
      rpress_ff   <= rpress_in;
      rdz_ff      <= rdz_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted item did not start the sequencer");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && (dcnt_ff == 6'd63) |=> state_ff == ST_RUN)
      else $error("divider did not finish after 64 steps");

   a_temp_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> !rsp_tuser[1] && rsp_tdata[63:32] == 32'd0)
      else $error("temperature result carries pressure fields");

   a_press_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[31:0] == 32'd0)
      else $error("pressure result carries a temperature");

   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[63:32] == 32'd0)
      else $error("zero divisor result not forced to zero");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   import brc_pkg::*;

   // Request item as the sensor delivers it: selector plus three burst bytes
   typedef struct {
      logic       is_press;
      logic [7:0] msb;
      logic [7:0] lsb;
      logic [7:0] xlsb;
   } reading_type;

   // Compensated result as the block must return it
   typedef struct {
      logic        is_press;
      logic [31:0] temp_centi;
      logic [31:0] press_q24_8;
      logic        div_zero;
   } comp_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // msb_byte, lsb_byte, xlsb_byte
   logic        req_tuser;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // temperature_centi, pressure_q24_8
   logic [1:0]  rsp_tuser;   // result_is_pressure, divide_by_zero
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   barometer_reading_compensation dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Shadow copy of the trim registers and the stored fine temperature
   logic [47:0] temp_trim_q;
   logic [63:0] press_trim_a_q;
   logic [63:0] press_trim_b_q;
   logic [15:0] press_trim_c_q;
   logic [31:0] fine_temp_q;

   reading_type     pending_readings[$];
   comp_result_type expected_results[$];
   int              errors;
   longint          cycle_count;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Signed 64-bit division, truncating toward zero; the most negative
   // dividend over -1 wraps to itself through the magnitude path.
   function automatic logic [63:0] div_trunc(logic [63:0] num, logic [63:0] den);
      logic [63:0] nm;
      logic [63:0] dm;
      logic [63:0] q;
      nm = num[63] ? (64'd0 - num) : num;
      dm = den[63] ? (64'd0 - den) : den;
      q = nm / dm;
      return (num[63] != den[63]) ? (64'd0 - q) : q;
   endfunction

   // Compensate one reading against the shadow trims; a temperature reading updates fine temperature
   function automatic comp_result_type compensate(reading_type r);
      comp_result_type    res;
      logic signed [31:0] adc, t1, t2, t3, a, tv1, d, dd, tv2, tf;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] v1, v2, p, h;
      adc = {12'd0, r.msb, r.lsb, r.xlsb[7:4]};
      res.is_press = r.is_press;
      res.temp_centi = 32'd0;
      res.press_q24_8 = 32'd0;
      res.div_zero = 1'b0;
      if (!r.is_press) begin
         t1 = {16'd0, temp_trim_q[15:0]};
         t2 = {{16{temp_trim_q[31]}}, temp_trim_q[31:16]};
         t3 = {{16{temp_trim_q[47]}}, temp_trim_q[47:32]};
         a = (adc >>> 3) - (t1 <<< 1);
         tv1 = (a * t2) >>> 11;
         d = (adc >>> 4) - t1;
         dd = (d * d) >>> 12;
         tv2 = (dd * t3) >>> 14;
         tf = tv1 + tv2;
         fine_temp_q = tf;
         res.temp_centi = (tf * 5 + 128) >>> 8;
         return res;
      end
      p1 = {48'd0, press_trim_a_q[15:0]};
      p2 = {{48{press_trim_a_q[31]}}, press_trim_a_q[31:16]};
      p3 = {{48{press_trim_a_q[47]}}, press_trim_a_q[47:32]};
      p4 = {{48{press_trim_a_q[63]}}, press_trim_a_q[63:48]};
      p5 = {{48{press_trim_b_q[15]}}, press_trim_b_q[15:0]};
      p6 = {{48{press_trim_b_q[31]}}, press_trim_b_q[31:16]};
      p7 = {{48{press_trim_b_q[47]}}, press_trim_b_q[47:32]};
      p8 = {{48{press_trim_b_q[63]}}, press_trim_b_q[63:48]};
      p9 = {{48{press_trim_c_q[15]}}, press_trim_c_q};
      v1 = {{32{fine_temp_q[31]}}, fine_temp_q};
      v1 = v1 - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      if (v1 == 64'sd0) begin
         res.div_zero = 1'b1;
         return res;
      end
      p = 64'sd1048576 - {32'd0, adc};
      p = div_trunc(((p <<< 31) - v2) * 64'sd3125, v1);
      h = p >>> 13;
      v1 = (p9 * h * h) >>> 25;
      v2 = (p8 * p) >>> 19;
      p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
      res.press_q24_8 = p[31:0];
      return res;
   endfunction

   // Sender: bursts of random length, random gaps after each burst
   int burst_left;
   int gap_left;
   reading_type on_wire;

   always @(posedge clock) begin
      logic        next_valid;
      reading_type rd;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= 24'd0;
         req_tuser <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_results.push_back(compensate(on_wire));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (pending_readings.size() > 0) begin
               rd = pending_readings.pop_front();
               on_wire = rd;
               req_tdata <= {rd.xlsb, rd.lsb, rd.msb};
               req_tuser <= rd.is_press;
               next_valid = 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // Receiver: own stall pattern, plus one long hold-off so the block backs up
   int ready_mode;
   int mode_left;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         cycle_count <= 0;
         ready_mode <= 0;
         mode_left <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(20, 300);
         end else begin
            mode_left <= mode_left - 1;
         end
         if (cycle_count >= 6000 && cycle_count < 7500)
            rsp_tready <= 1'b0;
         else case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 1);
            2: rsp_tready <= ($urandom_range(0, 7) == 0);
            default: rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      comp_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result tdata=%h tuser=%b", rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_tuser[0] !== exp_r.is_press) begin
               $error("result_is_pressure expected %b actual %b", exp_r.is_press,
                      rsp_tuser[0]);
               errors++;
            end
            if (rsp_tdata[31:0] !== exp_r.temp_centi) begin
               $error("temperature_centi expected %0d actual %0d",
                      $signed(exp_r.temp_centi), $signed(rsp_tdata[31:0]));
               errors++;
            end
            if (rsp_tdata[63:32] !== exp_r.press_q24_8) begin
               $error("pressure_q24_8 expected %h actual %h", exp_r.press_q24_8,
                      rsp_tdata[63:32]);
               errors++;
            end
            if (rsp_tuser[1] !== exp_r.div_zero) begin
               $error("divide_by_zero expected %b actual %b", exp_r.div_zero,
                      rsp_tuser[1]);
               errors++;
            end
         end
      end
   end

   // Write one trim register and mirror it in the shadow copy
   task automatic write_trim(logic [1:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TEMP_TRIM:    temp_trim_q = val[47:0];
         CSR_PRESS_TRIM_A: press_trim_a_q = val;
         CSR_PRESS_TRIM_B: press_trim_b_q = val;
         default:          press_trim_c_q = val[15:0];
      endcase
   endtask

   task automatic load_trims(logic [47:0] tt, logic [63:0] pa, logic [63:0] pb,
                             logic [15:0] pc);
      write_trim(CSR_TEMP_TRIM, {16'd0, tt});
      write_trim(CSR_PRESS_TRIM_A, pa);
      write_trim(CSR_PRESS_TRIM_B, pb);
      write_trim(CSR_PRESS_TRIM_C, {48'd0, pc});
   endtask

   // Hold until every reading is sent and answered, then let the pipe drain
   task automatic drain();
      while (pending_readings.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   function automatic reading_type make_reading(logic is_press, logic [7:0] m,
                                                logic [7:0] l, logic [7:0] x);
      reading_type r;
      r.is_press = is_press;
      r.msb = m;
      r.lsb = l;
      r.xlsb = x;
      return r;
   endfunction

   // Mostly temperature-then-pressure pairs near real sensor counts, some noise
   task automatic queue_random(int n);
      int k;
      int kind;
      for (k = 0; k < n; k++) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            pending_readings.push_back(make_reading(1'b0, 8'($urandom_range(100, 160)),
                                                    8'($urandom), 8'($urandom)));
            pending_readings.push_back(make_reading(1'b1, 8'($urandom_range(60, 120)),
                                                    8'($urandom), 8'($urandom)));
            k++;
         end else if (kind < 8) begin
            pending_readings.push_back(make_reading(1'($urandom_range(0, 1)),
                                                    8'($urandom), 8'($urandom),
                                                    8'($urandom)));
         end else begin
            pending_readings.push_back(make_reading(1'($urandom_range(0, 1)),
                                                    ($urandom_range(0, 1) ? 8'hFF : 8'h00),
                                                    ($urandom_range(0, 1) ? 8'hFF : 8'h00),
                                                    8'($urandom)));
         end
      end
   endtask

   // Typical factory trims
   localparam logic [47:0] TT_TYP = {16'hFC18, 16'd26435, 16'd27504};
   localparam logic [63:0] PA_TYP = {16'd2855, 16'd3024, 16'hD641, 16'd36477};
   localparam logic [63:0] PB_TYP = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
   localparam logic [15:0] PC_TYP = 16'd6000;

   initial begin
      errors = 0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = CSR_TEMP_TRIM;
      csr_data = 64'd0;
      temp_trim_q = 48'd0;
      press_trim_a_q = 64'd0;
      press_trim_b_q = 64'd0;
      press_trim_c_q = 16'd0;
      fine_temp_q = 32'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset trims: pressure before any temperature, zero divisor everywhere
      pending_readings.push_back(make_reading(1'b1, 8'h55, 8'hAA, 8'hF0));
      pending_readings.push_back(make_reading(1'b0, 8'h80, 8'h00, 8'h00));
      pending_readings.push_back(make_reading(1'b1, 8'hFF, 8'hFF, 8'hFF));
      drain();

      // Directed readings with typical trims: field extremes, both kinds
      load_trims(TT_TYP, PA_TYP, PB_TYP, PC_TYP);
      pending_readings.push_back(make_reading(1'b1, 8'h65, 8'h5A, 8'hC0));
      pending_readings.push_back(make_reading(1'b0, 8'h7E, 8'hED, 8'h00));
      pending_readings.push_back(make_reading(1'b1, 8'h65, 8'h5A, 8'hC0));
      pending_readings.push_back(make_reading(1'b0, 8'h00, 8'h00, 8'h00));
      pending_readings.push_back(make_reading(1'b1, 8'h00, 8'h00, 8'h00));
      pending_readings.push_back(make_reading(1'b0, 8'hFF, 8'hFF, 8'hFF));
      pending_readings.push_back(make_reading(1'b1, 8'hFF, 8'hFF, 8'hFF));
      pending_readings.push_back(make_reading(1'b1, 8'h80, 8'h00, 8'h0F));
      pending_readings.push_back(make_reading(1'b0, 8'h80, 8'h00, 8'h0F));
      pending_readings.push_back(make_reading(1'b1, 8'h7F, 8'hFF, 8'hF0));
      pending_readings.push_back(make_reading(1'b0, 8'hAA, 8'h55, 8'hA5));
      pending_readings.push_back(make_reading(1'b1, 8'h55, 8'hAA, 8'h5A));
      drain();

      // Extreme trims: all ones, then single sign bits
      load_trims({48{1'b1}}, {64{1'b1}}, {64{1'b1}}, 16'hFFFF);
      queue_random(40);
      drain();
      load_trims({16'h8000, 16'h8000, 16'hFFFF}, {4{16'h8000}} | 64'hFFFF,
                 {4{16'h8000}}, 16'h8000);
      queue_random(40);
      drain();

      // Typical trims with the long receiver hold-off falling in here
      load_trims(TT_TYP, PA_TYP, PB_TYP, PC_TYP);
      queue_random(275);
      drain();

      // Fully random trims
      load_trims(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                 16'($urandom));
      queue_random(100);
      drain();

      // Random trims near typical values, zero P1 for divide-by-zero once more
      load_trims(TT_TYP ^ {8'($urandom_range(0, 255)), 40'd0},
                 PA_TYP ^ 64'($urandom_range(0, 1023)),
                 PB_TYP ^ {$urandom, $urandom}, 16'($urandom));
      queue_random(150);
      drain();
      load_trims(TT_TYP, PA_TYP & ~64'hFFFF, PB_TYP, PC_TYP);
      queue_random(30);
      drain();

      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
